[hdl/rmcs_pkg.sv]
`default_nettype none

package rmcs_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned DivSteps = 8;
  localparam int unsigned StepW    = $clog2(DivSteps);

  localparam logic       REQ_SAMPLE   = 1'b0;
  localparam logic       REQ_CLASSIFY = 1'b1;

  localparam logic [PixW-1:0] MASK_HIT       = 8'd255;
  localparam logic [PixW-1:0] MASK_MISS      = 8'd0;
  localparam logic [PixW-1:0] MAX_DIFF_RESET = 8'd65;

  // controller -> datapath
  typedef struct packed {
    logic add_sample;   // accumulate a reference sample (if room)
    logic classify;     // classify the pixel into the output register
    logic load_div;     // last sample: latch dividends/divisor, clear sums
    logic step_div;     // one restoring-division step
    logic done_div;     // final step: commit means
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;     // output register holds a result not taken this cycle
  } status_t;

endpackage

`default_nettype wire

[hdl/rmcs_ctrl.sv]
`default_nettype none

module rmcs_ctrl
  import rmcs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_valid_i,
  input  wire logic    s_req_i,
  input  wire logic    s_last_i,
  output logic         s_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } state_e;

  state_e            state_q;
  logic [StepW-1:0]  step_q;
  logic              accept;

  assign s_ready_o = (state_q == ST_IDLE) && !status_i.out_busy;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    cmd_o            = '0;
    cmd_o.add_sample = accept && (s_req_i == REQ_SAMPLE);
    cmd_o.classify   = accept && (s_req_i == REQ_CLASSIFY);
    cmd_o.load_div   = accept && (s_req_i == REQ_SAMPLE) && s_last_i;
    cmd_o.step_div   = (state_q == ST_DIVIDE);
    cmd_o.done_div   = (state_q == ST_DIVIDE) && (step_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.load_div) begin
            state_q <= ST_DIVIDE;
            step_q  <= StepW'(DivSteps - 1);
          end
        end
        ST_DIVIDE: begin
          if (step_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/rmcs_datapath.sv]
`default_nettype none

module rmcs_datapath
  import rmcs_pkg::*;
#(
  parameter int unsigned MAX_REGION_PIXELS = 4096
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cmd_t            cmd_i,
  output status_t              status_o,
  input  wire logic [PixW-1:0] blue_i,
  input  wire logic [PixW-1:0] green_i,
  input  wire logic [PixW-1:0] red_i,
  input  wire logic            cfg_we_i,
  input  wire logic [PixW-1:0] cfg_wdata_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 out_match_o,
  output logic [PixW-1:0]      out_mask_o
);

  localparam int unsigned CntW = $clog2(MAX_REGION_PIXELS + 1);
  localparam int unsigned SumW = $clog2(MAX_REGION_PIXELS * 255 + 1);

  logic [PixW-1:0] max_diff_q;
  logic [SumW-1:0] sum_b_q, sum_g_q, sum_r_q;
  logic [SumW-1:0] sum_b_n, sum_g_n, sum_r_n;
  logic [CntW-1:0] cnt_q, cnt_n;
  logic            room;

  logic [SumW-1:0] rem_b_q, rem_g_q, rem_r_q;
  logic [SumW-1:0] dvs_q;
  logic [PixW-1:0] quo_b_q, quo_g_q, quo_r_q;
  logic            zero_cnt_q;
  logic            ge_b, ge_g, ge_r;

  logic [PixW-1:0] mean_b_q, mean_g_q, mean_r_q;
  logic [PixW-1:0] quo_b_n, quo_g_n, quo_r_n;

  logic [PixW:0]   dif_b, dif_g, dif_r;
  logic [PixW-1:0] abs_b, abs_g, abs_r;
  logic            hit;

  logic            out_vld_q;
  logic            out_match_q;
  logic [PixW-1:0] out_mask_q;

  // accumulate; the incoming sample is folded in before the divide loads
  assign room    = (cnt_q < CntW'(MAX_REGION_PIXELS));
  assign sum_b_n = room ? sum_b_q + SumW'(blue_i)  : sum_b_q;
  assign sum_g_n = room ? sum_g_q + SumW'(green_i) : sum_g_q;
  assign sum_r_n = room ? sum_r_q + SumW'(red_i)   : sum_r_q;
  assign cnt_n   = room ? cnt_q + 1'b1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_b_q    <= '0;
      sum_g_q    <= '0;
      sum_r_q    <= '0;
      cnt_q      <= '0;
      max_diff_q <= MAX_DIFF_RESET;
    end else begin
      if (cfg_we_i) begin
        max_diff_q <= cfg_wdata_i;
      end
      if (cmd_i.load_div) begin
        sum_b_q <= '0;
        sum_g_q <= '0;
        sum_r_q <= '0;
        cnt_q   <= '0;
      end else if (cmd_i.add_sample) begin
        sum_b_q <= sum_b_n;
        sum_g_q <= sum_g_n;
        sum_r_q <= sum_r_n;
        cnt_q   <= cnt_n;
      end
    end
  end

  // restoring divider, shared divisor, 8 quotient bits (mean < 256)
  assign ge_b    = (rem_b_q >= dvs_q);
  assign ge_g    = (rem_g_q >= dvs_q);
  assign ge_r    = (rem_r_q >= dvs_q);
  assign quo_b_n = {quo_b_q[PixW-2:0], ge_b};
  assign quo_g_n = {quo_g_q[PixW-2:0], ge_g};
  assign quo_r_n = {quo_r_q[PixW-2:0], ge_r};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_div) begin
      rem_b_q    <= sum_b_n;
      rem_g_q    <= sum_g_n;
      rem_r_q    <= sum_r_n;
      dvs_q      <= SumW'(cnt_n) << (DivSteps - 1);
      zero_cnt_q <= (cnt_n == '0);
      quo_b_q    <= '0;
      quo_g_q    <= '0;
      quo_r_q    <= '0;
    end else if (cmd_i.step_div) begin
      rem_b_q <= ge_b ? rem_b_q - dvs_q : rem_b_q;
      rem_g_q <= ge_g ? rem_g_q - dvs_q : rem_g_q;
      rem_r_q <= ge_r ? rem_r_q - dvs_q : rem_r_q;
      dvs_q   <= dvs_q >> 1;
      quo_b_q <= quo_b_n;
      quo_g_q <= quo_g_n;
      quo_r_q <= quo_r_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_b_q <= '0;
      mean_g_q <= '0;
      mean_r_q <= '0;
    end else if (cmd_i.done_div) begin
      mean_b_q <= zero_cnt_q ? '0 : quo_b_n;
      mean_g_q <= zero_cnt_q ? '0 : quo_g_n;
      mean_r_q <= zero_cnt_q ? '0 : quo_r_n;
    end
  end

  // classify
  assign dif_b = {1'b0, blue_i}  - {1'b0, mean_b_q};
  assign dif_g = {1'b0, green_i} - {1'b0, mean_g_q};
  assign dif_r = {1'b0, red_i}   - {1'b0, mean_r_q};
  assign abs_b = dif_b[PixW] ? PixW'(-dif_b) : dif_b[PixW-1:0];
  assign abs_g = dif_g[PixW] ? PixW'(-dif_g) : dif_g[PixW-1:0];
  assign abs_r = dif_r[PixW] ? PixW'(-dif_r) : dif_r[PixW-1:0];
  assign hit   = (abs_b < max_diff_q) && (abs_g < max_diff_q) && (abs_r < max_diff_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.classify) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      out_match_q <= hit;
      out_mask_q  <= hit ? MASK_HIT : MASK_MISS;
    end
  end

  assign status_o.out_busy = out_vld_q && !out_ready_i;
  assign out_valid_o       = out_vld_q;
  assign out_match_o       = out_match_q;
  assign out_mask_o        = out_mask_q;

endmodule

`default_nettype wire

[hdl/roi_mean_color_segmenter.sv]
`default_nettype none

// ROI mean color segmenter. Reference samples (tuser = 0) are summed per
// channel and counted, up to MAX_REGION_PIXELS per region; extra samples are
// dropped. The sample carrying tlast closes the region: it is added first,
// then each channel mean becomes sum / count (truncating, 0 for an empty
// region) and the sums clear. Pixels to classify (tuser = 1) produce one
// output transaction each: tuser = match, tdata = 255 on a match, else 0. A
// pixel matches when |pixel - mean| < max_diff on all three channels.
// max_diff resets to 65 and is written through cfg_we_i/cfg_wdata_i; the
// user must write it only while the block is idle; the block itself does
// not enforce this. Rate: one input transaction per cycle for samples and
// classify pixels, as long as the output register is free or being drained.
// The closing sample starts a shared-divisor restoring divider for the three
// means, one quotient bit per cycle; tready stays low until it is done.

module roi_mean_color_segmenter
  import rmcs_pkg::*;
#(
  parameter int unsigned MAX_REGION_PIXELS = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: max_diff
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // [7:0] blue, [15:8] green, [23:16] red
  input  wire logic        s_axis_tuser_i,   // [0] req_type
  input  wire logic        s_axis_tlast_i,   // last_sample
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] mask_value
  output logic             m_axis_tuser_o    // [0] is_match
);

  cmd_t    cmd;
  status_t status;

  rmcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_req_i   (s_axis_tuser_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rmcs_datapath #(
    .MAX_REGION_PIXELS (MAX_REGION_PIXELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .blue_i      (s_axis_tdata_i[7:0]),
    .green_i     (s_axis_tdata_i[15:8]),
    .red_i       (s_axis_tdata_i[23:16]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_match_o (m_axis_tuser_o),
    .out_mask_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

[test/tb_roi_mean_color_segmenter.sv]
`default_nettype none

// Checks roi_mean_color_segmenter end to end. A table of hand-made
// transactions goes first: classify before any region, mask extremes, the
// exact max_diff boundary on each channel, tlast on a classify pixel, a
// one-sample region and a region whose first sample dominates the mean.
// Random phases follow, each under a new max_diff (0, 255, 1 and random
// values). Most random traffic is whole regions followed by pixels scattered
// around the new means. The rest is loose samples, half-open regions and
// noise pixels. The region capacity is made small so that full regions, with
// dropped samples and a dropped closing sample, happen often. Both stream
// sides idle at random.

module tb_roi_mean_color_segmenter;
  import rmcs_pkg::*;

  // Small capacity so the region-full path is reached many times per run.
  localparam int unsigned REGION_CAP  = 24;
  // Closing sample starts the division; settle a little longer than it takes.
  localparam int unsigned DIV_SETTLE  = 12;
  // Cycles without any transaction before the run is declared hung.
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned PHASE_ITEMS = 106;
  localparam int unsigned NUM_ROWS    = 19;

  typedef struct packed {
    logic       is_match;
    logic [7:0] mask_value;
  } seg_result_t;

  // One row of the directed table. known marks rows whose result is typed in.
  typedef struct packed {
    logic       req;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
    logic       known;
    logic       known_hit;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // [7:0] blue, [15:8] green, [23:16] red
  logic        s_axis_tuser_i;   // [0] req_type
  logic        s_axis_tlast_i;   // last_sample
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // [7:0] mask_value
  logic        m_axis_tuser_o;   // [0] is_match

  // Expected classify results, oldest first.
  seg_result_t pending_masks[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned tx_calm        = 0;

  // Shadow of the block: threshold, running region sums and current means.
  logic [7:0]  thr_diff = MAX_DIFF_RESET;
  logic [19:0] sum_b = '0, sum_g = '0, sum_r = '0;
  logic [12:0] region_count = '0;
  logic [7:0]  mean_b = '0, mean_g = '0, mean_r = '0;

  stim_row_t   directed_rows [NUM_ROWS];

  roi_mean_color_segmenter #(
    .MAX_REGION_PIXELS(REGION_CAP)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] chan_gap(logic [7:0] a, logic [7:0] m);
    return (a >= m) ? a - m : m - a;
  endfunction

  // Value within +/- reach of center, clamped to the pixel range.
  function automatic logic [7:0] jitter(logic [7:0] center, int unsigned reach);
    int v;
    v = int'(center) + int'($urandom_range(0, 2 * reach)) - int'(reach);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Advance the shadow by one accepted transaction; classify pixels yield a result.
  task automatic segment_pixel(input logic req, input logic [7:0] b, input logic [7:0] g,
                               input logic [7:0] r, input logic last,
                               output logic produced, output seg_result_t res);
    logic hit;
    res = '0;
    produced = 1'b0;
    if (req == REQ_SAMPLE) begin
      // samples past capacity are dropped, but tlast still closes the region
      if (region_count < REGION_CAP) begin
        sum_b = sum_b + 20'(b);
        sum_g = sum_g + 20'(g);
        sum_r = sum_r + 20'(r);
        region_count = region_count + 1'b1;
      end
      if (last) begin
        mean_b = (region_count == 0) ? 8'd0 : 8'(sum_b / region_count);
        mean_g = (region_count == 0) ? 8'd0 : 8'(sum_g / region_count);
        mean_r = (region_count == 0) ? 8'd0 : 8'(sum_r / region_count);
        sum_b = '0;
        sum_g = '0;
        sum_r = '0;
        region_count = '0;
      end
    end else begin
      // tlast means nothing on a classify pixel
      hit = (chan_gap(b, mean_b) < thr_diff) && (chan_gap(g, mean_g) < thr_diff) &&
            (chan_gap(r, mean_r) < thr_diff);
      produced = 1'b1;
      res.is_match = hit;
      res.mask_value = hit ? MASK_HIT : MASK_MISS;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_pixel(input logic req, input logic [7:0] b, input logic [7:0] g,
                            input logic [7:0] r, input logic last,
                            input logic known, input logic known_hit);
    int unsigned gap;
    logic        produced;
    seg_result_t res;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) tx_calm = $urandom_range(15, 60);
      gap = draw_gap();
    end
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  = {r, g, b};
    s_axis_tuser_i  = req;
    s_axis_tlast_i  = last;
    s_axis_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    segment_pixel(req, b, g, r, last, produced, res);
    if (produced) begin
      if (known) begin
        res.is_match = known_hit;
        res.mask_value = known_hit ? MASK_HIT : MASK_MISS;
      end
      pending_masks.push_back(res);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // Change max_diff only once the block has drained and any division is over.
  task automatic write_max_diff(input logic [7:0] value);
    s_axis_tvalid_i = 1'b0;
    while (pending_masks.size() != 0) @(negedge clk_i);
    repeat (DIV_SETTLE) @(negedge clk_i);
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    thr_diff = value;
  endtask

  // Random traffic: mostly whole regions followed by pixels near the new means.
  task automatic run_phase(input int unsigned budget);
    int unsigned stop_at, pick, len, spread, n;
    logic [7:0]  base_b, base_g, base_r;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(REGION_CAP - 2, REGION_CAP + 4)
                                          : $urandom_range(1, 6);
        spread = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 40);
        base_b = 8'($urandom_range(0, 255));
        base_g = 8'($urandom_range(0, 255));
        base_r = 8'($urandom_range(0, 255));
        for (int unsigned i = 0; i < len; i++)
          push_pixel(REQ_SAMPLE, jitter(base_b, spread), jitter(base_g, spread),
                     jitter(base_r, spread), i == len - 1, 1'b0, 1'b0);
        n = $urandom_range(1, 8);
        // reach just past the threshold so both sides of the boundary show up
        for (int unsigned i = 0; i < n; i++)
          push_pixel(REQ_CLASSIFY, jitter(mean_b, thr_diff + 1), jitter(mean_g, thr_diff + 1),
                     jitter(mean_r, thr_diff + 1), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end else if (pick < 85) begin
        // loose samples; the region may stay open across other traffic
        n = $urandom_range(1, 4);
        for (int unsigned i = 0; i < n; i++)
          push_pixel(REQ_SAMPLE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, 1'b0);
      end else begin
        n = $urandom_range(1, 3);
        for (int unsigned i = 0; i < n; i++)
          push_pixel(REQ_CLASSIFY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end
    end
  endtask

  // Result side: random back-pressure with some stall-free stretches.
  initial begin : result_sink
    int unsigned rx_hold, rx_calm, pick;
    rx_hold = 0;
    rx_calm = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready_i = 1'b0;
      end else if (rx_calm > 0) begin
        rx_calm--;
        m_axis_tready_i = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 6) rx_calm = $urandom_range(20, 80);
        else if (pick < 35) rx_hold = draw_gap();
        m_axis_tready_i = (rx_hold == 0);
      end
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_masks.size() == 0) begin
        $error("unexpected result: is_match %0d, mask_value %0d",
               m_axis_tuser_o, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        if (m_axis_tuser_o !== pending_masks[0].is_match) begin
          $error("is_match: expected %0d, got %0d", pending_masks[0].is_match,
                 m_axis_tuser_o);
          mismatch_count++;
        end
        if (m_axis_tdata_o !== pending_masks[0].mask_value) begin
          $error("mask_value: expected %0d, got %0d", pending_masks[0].mask_value,
                 m_axis_tdata_o);
          mismatch_count++;
        end
        void'(pending_masks.pop_front());
      end
    end
  end

  // Hang detector: too many cycles in a row without a transaction on either side.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_roi_mean_color_segmenter: FAIL");
    $finish;
  end

  initial begin : main_flow
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_SAMPLE;
    s_axis_tlast_i  = 1'b0;

    // req, blue, green, red, last, known, known_hit (threshold at reset: 65)
    directed_rows = '{
      // before any region the means are all zero
      '{REQ_CLASSIFY, 8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b1},
      '{REQ_CLASSIFY, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0},
      '{REQ_CLASSIFY, 8'd64,  8'd64,  8'd64,  1'b0, 1'b1, 1'b1},
      '{REQ_CLASSIFY, 8'd0,   8'd65,  8'd0,   1'b0, 1'b1, 1'b0},
      // first sample carries all the blue: means 85 / 85 / 66
      '{REQ_SAMPLE,   8'd255, 8'd0,   8'd200, 1'b0, 1'b0, 1'b0},
      '{REQ_SAMPLE,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0},
      '{REQ_SAMPLE,   8'd0,   8'd255, 8'd0,   1'b1, 1'b0, 1'b0},
      '{REQ_CLASSIFY, 8'd85,  8'd85,  8'd66,  1'b0, 1'b1, 1'b1},
      '{REQ_CLASSIFY, 8'd150, 8'd85,  8'd66,  1'b0, 1'b1, 1'b0},
      // tlast on a classify pixel must not close a region
      '{REQ_CLASSIFY, 8'd21,  8'd149, 8'd2,   1'b1, 1'b1, 1'b1},
      '{REQ_CLASSIFY, 8'd85,  8'd20,  8'd66,  1'b0, 1'b1, 1'b0},
      // one-sample region
      '{REQ_SAMPLE,   8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0},
      '{REQ_CLASSIFY, 8'd191, 8'd255, 8'd255, 1'b0, 1'b1, 1'b1},
      '{REQ_CLASSIFY, 8'd255, 8'd255, 8'd190, 1'b0, 1'b1, 1'b0},
      '{REQ_SAMPLE,   8'd17,  8'd200, 8'd99,  1'b0, 1'b0, 1'b0},
      '{REQ_SAMPLE,   8'd3,   8'd4,   8'd5,   1'b0, 1'b0, 1'b0},
      '{REQ_SAMPLE,   8'd250, 8'd1,   8'd128, 1'b1, 1'b0, 1'b0},
      '{REQ_CLASSIFY, 8'd90,  8'd68,  8'd77,  1'b0, 1'b0, 1'b0},
      '{REQ_CLASSIFY, 8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 1'b0}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      push_pixel(directed_rows[i].req, directed_rows[i].blue, directed_rows[i].green,
                 directed_rows[i].red, directed_rows[i].last, directed_rows[i].known,
                 directed_rows[i].known_hit);

    // threshold extremes first (nothing can match at 0), then random values
    write_max_diff(8'd0);
    run_phase(PHASE_ITEMS);
    write_max_diff(8'd255);
    run_phase(PHASE_ITEMS);
    write_max_diff(8'd1);
    run_phase(PHASE_ITEMS);
    write_max_diff(8'($urandom_range(2, 254)));
    run_phase(PHASE_ITEMS);
    write_max_diff(8'($urandom_range(20, 100)));
    run_phase(PHASE_ITEMS);

    s_axis_tvalid_i = 1'b0;
    while (pending_masks.size() != 0) @(posedge clk_i);
    repeat (DIV_SETTLE) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("tb_roi_mean_color_segmenter: PASS");
    else
      $display("tb_roi_mean_color_segmenter: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
